[sv/dtpv_pkg.sv]
`default_nettype none
package dtpv_pkg;

  localparam int unsigned MaxLineCharsDefault = 49;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } dtpv_in_t;

  typedef struct packed {
    logic        date_valid;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } dtpv_out_t;

  // One classified character (or end-of-line marker) handed from front to back.
  typedef struct packed {
    logic       line_end;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_slash;
    logic       is_blank;
    logic       is_lead;
    logic       is_nul;
  } dtpv_tok_t;

  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSlash = 8'd47;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;
  localparam logic [7:0] ChNul   = 8'd0;

endpackage
`default_nettype wire

[sv/dtpv_front.sv]
`default_nettype none
module dtpv_front
  import dtpv_pkg::*;
(
  input  wire logic      in_valid,
  input  wire dtpv_in_t  in_data,
  output logic           in_stall,
  input  wire logic      q_full,
  output logic           q_push,
  output dtpv_tok_t      q_tok
);

  logic [7:0] c;
  logic [7:0] c_off;

  assign c        = in_data.char_code;
  assign c_off    = c - ChZero;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the byte; the back end only sees flags and the digit value.
  always_comb begin
    q_tok          = '0;
    q_tok.line_end = in_data.line_end;
    q_tok.is_digit = (c >= ChZero) && (c <= ChNine);
    q_tok.digit    = q_tok.is_digit ? c_off[3:0] : 4'd0;
    q_tok.is_slash = (c == ChSlash);
    q_tok.is_blank = (c == ChSpace) || (c == ChTab) || (c == ChCr);
    q_tok.is_lead  = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    q_tok.is_nul   = (c == ChNul);
  end

endmodule
`default_nettype wire

[sv/dtpv_queue.sv]
`default_nettype none
module dtpv_queue
  import dtpv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire dtpv_tok_t push_tok,
  output logic           full,
  output logic           head_valid,
  output dtpv_tok_t      head_tok,
  input  wire logic      pop
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  dtpv_tok_t         mem_r [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == CntW'(QueueDepth));
  assign head_valid = (count_r != '0);
  assign head_tok   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule
`default_nettype wire

[sv/dtpv_back.sv]
`default_nettype none
module dtpv_back
  import dtpv_pkg::*;
#(
  parameter int unsigned MAX_LINE_CHARS = MaxLineCharsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      tok_valid,
  input  wire dtpv_tok_t tok,
  output logic           tok_pop,
  output logic           out_valid,
  output dtpv_out_t      out_data,
  input  wire logic      out_stall
);

  localparam int unsigned CntW = $clog2(MAX_LINE_CHARS + 1);

  typedef enum logic [5:0] {
    PH_SKIP  = 6'b000001,
    PH_DAY   = 6'b000010,
    PH_MONTH = 6'b000100,
    PH_YEAR  = 6'b001000,
    PH_TRAIL = 6'b010000,
    PH_ERR   = 6'b100000
  } phase_t;

  function automatic logic [4:0] month_len(input logic [6:0] m);
    logic [4:0] r;
    begin
      unique case (m)
        7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
        7'd2:                    r = 5'd28;
        default:                 r = 5'd31;
      endcase
      return r;
    end
  endfunction

  function automatic logic [2:0] mod5(input logic [4:0] v);
    logic [4:0] r;
    begin
      priority if (v >= 5'd20) r = v - 5'd20;
      else if (v >= 5'd15)     r = v - 5'd15;
      else if (v >= 5'd10)     r = v - 5'd10;
      else if (v >= 5'd5)      r = v - 5'd5;
      else                     r = v;
      return r[2:0];
    end
  endfunction

  function automatic logic [6:0] small_accum(input logic [6:0] acc, input logic [3:0] d);
    logic [9:0] v;
    begin
      v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {6'd0, d};
      return (v > 10'd99) ? 7'd99 : v[6:0];
    end
  endfunction

  phase_t          phase_r, phase_nxt;
  logic [6:0]      day_r, day_nxt;
  logic [6:0]      mon_r, mon_nxt;
  logic [15:0]     year_r, year_nxt;
  logic [4:0]      y25_r, y25_nxt;
  logic            yovf_r, yovf_nxt;
  logic            seen_r, seen_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            ended_r, ended_nxt;
  logic            out_valid_r, out_valid_nxt;
  dtpv_out_t       out_data_r, out_data_nxt;

  logic        out_free;
  logic        ok;
  logic        leap;
  logic [4:0]  lim;
  logic [19:0] year_ext;
  logic [5:0]  y25_step;
  phase_t      ph;

  assign out_free  = !out_valid_r || !out_stall;
  assign tok_pop   = tok_valid && (!tok.line_end || out_free);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign year_ext = {1'b0, year_r, 3'b000} + {3'b000, year_r, 1'b0} + {16'd0, tok.digit};
  assign y25_step = 6'(mod5(y25_r)) * 6'd10 + {2'b00, tok.digit};

  // Leap test without dividers: mod 4 and mod 16 from the low bits, mod 25 kept on the side.
  assign leap = ((year_r[1:0] == 2'b00) && (y25_r != 5'd0)) ||
                ((year_r[3:0] == 4'b0000) && (y25_r == 5'd0));
  assign lim  = month_len(mon_r) + {4'd0, (mon_r == 7'd2) && leap};
  assign ok   = (((phase_r == PH_YEAR) && seen_r) || (phase_r == PH_TRAIL)) &&
                !yovf_r && (day_r != 7'd0) && (mon_r != 7'd0) && (year_r != 16'd0) &&
                (mon_r <= 7'd12) && (day_r <= {2'b00, lim});

  always_comb begin
    phase_nxt     = phase_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    year_nxt      = year_r;
    y25_nxt       = y25_r;
    yovf_nxt      = yovf_r;
    seen_nxt      = seen_r;
    cnt_nxt       = cnt_r;
    ended_nxt     = ended_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ph            = phase_r;

    if (tok_pop) begin
      if (tok.line_end) begin
        if (phase_r != PH_SKIP) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.date_valid = ok;
          out_data_nxt.day        = ok ? day_r[4:0] : 5'd0;
          out_data_nxt.month      = ok ? mon_r[3:0] : 4'd0;
          out_data_nxt.year       = ok ? year_r : 16'd0;
        end
        phase_nxt = PH_SKIP;
        day_nxt   = '0;
        mon_nxt   = '0;
        year_nxt  = '0;
        y25_nxt   = '0;
        yovf_nxt  = 1'b0;
        seen_nxt  = 1'b0;
        cnt_nxt   = '0;
        ended_nxt = 1'b0;
      end else if (!((phase_r == PH_SKIP) && tok.is_lead)) begin
        if (phase_r == PH_SKIP) begin
          ph = PH_DAY;
        end
        phase_nxt = ph;
        if (cnt_r >= CntW'(MAX_LINE_CHARS)) begin
          phase_nxt = PH_ERR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (!ended_r && (ph != PH_ERR)) begin
            if (tok.is_nul) begin
              ended_nxt = 1'b1;
            end else begin
              unique case (ph)
                PH_DAY, PH_MONTH: begin
                  if (tok.is_digit) begin
                    if (ph == PH_DAY) begin
                      day_nxt = small_accum(day_r, tok.digit);
                    end else begin
                      mon_nxt = small_accum(mon_r, tok.digit);
                    end
                    seen_nxt = 1'b1;
                  end else if (tok.is_slash && seen_r) begin
                    phase_nxt = (ph == PH_DAY) ? PH_MONTH : PH_YEAR;
                    seen_nxt  = 1'b0;
                  end else begin
                    phase_nxt = PH_ERR;
                  end
                end
                PH_YEAR: begin
                  if (tok.is_digit) begin
                    if (!yovf_r) begin
                      if (year_ext > 20'd65535) begin
                        yovf_nxt = 1'b1;
                        year_nxt = 16'hFFFF;
                      end else begin
                        year_nxt = year_ext[15:0];
                      end
                      y25_nxt = (y25_step >= 6'd25) ? 5'(y25_step - 6'd25) : y25_step[4:0];
                    end
                    seen_nxt = 1'b1;
                  end else if (tok.is_blank && seen_r) begin
                    phase_nxt = PH_TRAIL;
                  end else begin
                    phase_nxt = PH_ERR;
                  end
                end
                PH_TRAIL: begin
                  if (!tok.is_blank) begin
                    phase_nxt = PH_ERR;
                  end
                end
                default: begin
                  phase_nxt = PH_ERR;
                end
              endcase
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      day_r       <= '0;
      mon_r       <= '0;
      year_r      <= '0;
      y25_r       <= '0;
      yovf_r      <= 1'b0;
      seen_r      <= 1'b0;
      cnt_r       <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      day_r       <= day_nxt;
      mon_r       <= mon_nxt;
      year_r      <= year_nxt;
      y25_r       <= y25_nxt;
      yovf_r      <= yovf_nxt;
      seen_r      <= seen_nxt;
      cnt_r       <= cnt_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

[sv/date_text_parse_validate_core.sv]
`default_nettype none
// Channel  Direction  Beat                          Handshake
// in_      input      dtpv_in_t  (char, line_end)   in_valid / in_stall
// out_     output     dtpv_out_t (valid, d/m/y)     out_valid / out_stall
//
// One beat a cycle sustained while no result waits: the front end classifies
// a character into a two-entry queue and the back end takes one queued beat a
// cycle. A result is registered as its line_end beat leaves the queue, held
// until taken. Reset is synchronous, active low, and leaves the parser
// skipping blanks. A waiting result holds a line_end beat at the queue head;
// the input stalls once both entries are full.
module date_text_parse_validate_core
  import dtpv_pkg::*;
#(
  parameter int unsigned MAX_LINE_CHARS = MaxLineCharsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire dtpv_in_t  in_data,
  output logic           in_stall,
  output logic           out_valid,
  output dtpv_out_t      out_data,
  input  wire logic      out_stall
);

  logic      q_full;
  logic      q_push;
  dtpv_tok_t q_in_tok;
  logic      q_head_valid;
  dtpv_tok_t q_head_tok;
  logic      q_pop;

  // Classify each beat and hand it to the queue.
  dtpv_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tok    (q_in_tok)
  );

  // Decouple the front end from a stalled output.
  dtpv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (q_in_tok),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_tok   (q_head_tok),
    .pop        (q_pop)
  );

  // Parse, validate the calendar date and register the result.
  dtpv_back #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_head_valid),
    .tok       (q_head_tok),
    .tok_pop   (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

[sim/tb_date_text_parse_validate_core.sv]
`default_nettype none
module tb_date_text_parse_validate_core;
  import dtpv_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxChars   = MaxLineCharsDefault;
  localparam int unsigned DrainTail  = 20;

  // Whitespace codes the package does not name.
  localparam logic [7:0] ChVt = 8'd11;
  localparam logic [7:0] ChFf = 8'd12;

  typedef enum logic [2:0] {
    LN_LEAD, LN_DAY, LN_MONTH, LN_YEAR, LN_TAIL, LN_BAD
  } line_phase_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  dtpv_in_t  in_data;
  logic      in_stall;
  logic      out_valid;
  dtpv_out_t out_data;
  logic      out_stall;

  // Idling knobs, in percent per cycle.
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatch_cnt;

  // Predictor state for the line currently being parsed.
  line_phase_t ln_phase;
  logic [6:0]  day_acc;
  logic [6:0]  mon_acc;
  logic [15:0] yr_acc;
  logic        yr_ovf;
  logic        num_seen;
  logic        nul_seen;
  logic [7:0]  n_chars;

  dtpv_out_t expected_dates[$];

  date_text_parse_validate_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake or a missing result ends here.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_lead_ws(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_trail_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChCr;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic logic calendar_ok(int unsigned d, int unsigned m, int unsigned y);
    if (d == 0 || m == 0 || y == 0 || m > 12) return 1'b0;
    return d <= days_in_month(m, y);
  endfunction

  // Decimal accumulate, pinned at 99.
  function automatic logic [6:0] sat_accum(logic [6:0] acc, logic [3:0] d);
    int unsigned v;
    v = acc * 10 + d;
    return (v > 99) ? 7'd99 : 7'(v);
  endfunction

  function automatic void clear_line_parser();
    ln_phase = LN_LEAD;
    day_acc  = '0;
    mon_acc  = '0;
    yr_acc   = '0;
    yr_ovf   = 1'b0;
    num_seen = 1'b0;
    nul_seen = 1'b0;
    n_chars  = '0;
  endfunction

  function automatic void advance_line_parser(dtpv_in_t b);
    dtpv_out_t   r;
    logic        ok;
    logic [7:0]  c;
    logic        dig;
    logic [3:0]  d;
    int unsigned v;
    c   = b.char_code;
    dig = (c >= ChZero) && (c <= ChNine);
    d   = 4'(c - ChZero);
    if (b.line_end) begin
      // A line that never left the leading blanks is dropped silently.
      if (ln_phase == LN_LEAD) return;
      ok = ((ln_phase == LN_YEAR && num_seen) || ln_phase == LN_TAIL) && !yr_ovf &&
           calendar_ok(day_acc, mon_acc, yr_acc);
      r = '0;
      if (ok) begin
        r.date_valid = 1'b1;
        r.day        = day_acc[4:0];
        r.month      = mon_acc[3:0];
        r.year       = yr_acc;
      end
      expected_dates.push_back(r);
      clear_line_parser();
      return;
    end
    if (ln_phase == LN_LEAD) begin
      if (is_lead_ws(c)) return;
      ln_phase = LN_DAY;
    end
    // Once the limit is reached every further character spoils the line.
    if (n_chars >= MaxChars) begin
      ln_phase = LN_BAD;
      return;
    end
    n_chars++;
    // After a NUL or an error the rest only counts towards the limit.
    if (nul_seen || ln_phase == LN_BAD) return;
    if (c == ChNul) begin
      nul_seen = 1'b1;
      return;
    end
    case (ln_phase)
      LN_DAY, LN_MONTH: begin
        if (dig) begin
          if (ln_phase == LN_DAY) day_acc = sat_accum(day_acc, d);
          else                    mon_acc = sat_accum(mon_acc, d);
          num_seen = 1'b1;
        end else if (c == ChSlash && num_seen) begin
          ln_phase = (ln_phase == LN_DAY) ? LN_MONTH : LN_YEAR;
          num_seen = 1'b0;
        end else begin
          ln_phase = LN_BAD;
        end
      end
      LN_YEAR: begin
        if (dig) begin
          // Once past 65535 the year is pinned and the line is doomed.
          if (!yr_ovf) begin
            v = yr_acc * 10 + d;
            if (v > 65535) begin
              yr_ovf = 1'b1;
              v      = 65535;
            end
            yr_acc = 16'(v);
          end
          num_seen = 1'b1;
        end else if (is_trail_blank(c) && num_seen) begin
          ln_phase = LN_TAIL;
        end else begin
          ln_phase = LN_BAD;
        end
      end
      LN_TAIL: if (!is_trail_blank(c)) ln_phase = LN_BAD;
      default: ln_phase = LN_BAD;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    if (mismatch_cnt < 200) $display("mismatch at %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  task automatic check_date(dtpv_out_t got);
    dtpv_out_t want;
    if (expected_dates.size() == 0) begin
      report_mismatch($sformatf("unexpected result %b %0d/%0d/%0d",
                                got.date_valid, got.day, got.month, got.year));
      return;
    end
    want = expected_dates.pop_front();
    if (got.date_valid !== want.date_valid)
      report_mismatch($sformatf("date_valid %b, want %b", got.date_valid, want.date_valid));
    if (got.day !== want.day)
      report_mismatch($sformatf("day %0d, want %0d", got.day, want.day));
    if (got.month !== want.month)
      report_mismatch($sformatf("month %0d, want %0d", got.month, want.month));
    if (got.year !== want.year)
      report_mismatch($sformatf("year %0d, want %0d", got.year, want.year));
  endtask

  // A result beat is taken at the rising edge where valid is high and our
  // stall (set at the previous falling edge) is low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_date(out_data);
  end

  // Receiver: decide the stall for the next edge at each falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Entered and left at a falling edge. Valid stays high into the next beat
  // unless an idle cycle is drawn, so it is never dropped and raised in one step.
  task automatic send_beat(dtpv_in_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    // Hold the payload until the block takes it.
    do @(posedge clk); while (in_stall);
    advance_line_parser(b);
    @(negedge clk);
  endtask

  function automatic void add_text(ref logic [7:0] txt[$], input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  task automatic send_line(logic [7:0] txt[$]);
    foreach (txt[i]) send_beat(dtpv_in_t'{char_code: txt[i], line_end: 1'b0});
    // The character slot of the end-of-line beat is junk and must be ignored.
    send_beat(dtpv_in_t'{char_code: 8'($urandom_range(255)), line_end: 1'b1});
  endtask

  task automatic send_text(string s);
    logic [7:0] txt[$];
    add_text(txt, s);
    send_line(txt);
  endtask

  function automatic logic [7:0] pick_lead_ws();
    case ($urandom_range(5))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChLf;
      3:       return ChVt;
      4:       return ChFf;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0:       return ChSpace;
      1:       return ChTab;
      default: return ChCr;
    endcase
  endfunction

  // Decimal number, now and then with leading zeros.
  function automatic void add_number(ref logic [7:0] txt[$], input int unsigned v);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) txt.push_back(ChZero);
    add_text(txt, $sformatf("%0d", v));
  endfunction

  // Mostly well-formed dates near the calendar edges; the rest is corrupted,
  // cut by a NUL, padded around the length limit, blank or plain noise.
  task automatic build_random_line(ref logic [7:0] txt[$]);
    int unsigned kind, r, d, m, y, lim, pos;
    txt  = {};
    kind = $urandom_range(99);
    if (kind >= 94) begin
      repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(255)));
      return;
    end
    if (kind >= 90) begin
      repeat ($urandom_range(0, 6)) txt.push_back(pick_lead_ws());
      return;
    end
    case ($urandom_range(9))
      0:       y = $urandom_range(1, 3000);
      1:       y = 100 * $urandom_range(15, 25);
      2:       y = 4 * $urandom_range(1, 16383);
      3:       y = 0;
      4:       y = 65535;
      5:       y = $urandom_range(65536, 1_000_000);
      default: y = $urandom_range(1, 65535);
    endcase
    r = $urandom_range(99);
    if (r < 20)      m = 2;
    else if (r < 88) m = $urandom_range(1, 12);
    else if (r < 94) m = $urandom_range(1) ? 0 : 13;
    else             m = $urandom_range(14, 150);
    if (m >= 1 && m <= 12) begin
      lim = days_in_month(m, y);
      r   = $urandom_range(99);
      if (r < 80)      d = $urandom_range(1, lim);
      else if (r < 88) d = lim + 1;
      else if (r < 92) d = 0;
      else             d = $urandom_range(32, 200);
    end else begin
      d = $urandom_range(1, 31);
    end
    repeat ($urandom_range(0, 2)) txt.push_back(pick_lead_ws());
    add_number(txt, d);
    txt.push_back(ChSlash);
    add_number(txt, m);
    txt.push_back(ChSlash);
    add_number(txt, y);
    repeat ($urandom_range(0, 3)) txt.push_back(pick_blank());
    if (kind >= 70 && kind < 78) begin
      pos = $urandom_range(0, txt.size() - 1);
      if ($urandom_range(1)) txt[pos] = 8'($urandom_range(255));
      else                   txt.insert(pos, 8'($urandom_range(255)));
    end else if (kind >= 78 && kind < 84) begin
      pos = $urandom_range(0, txt.size());
      txt.insert(pos, ChNul);
      repeat ($urandom_range(0, 5)) txt.push_back(8'($urandom_range(255)));
    end else if (kind >= 84) begin
      // Straddle the length limit.
      repeat ($urandom_range(35, 50)) txt.push_back(pick_blank());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_valid_dates();
    send_text("1/1/1");
    send_text("31/12/65535");
    send_text("29/2/2000");
    send_text("\t 007/03/02024 \t\r");
  endtask

  task automatic test_calendar_rejects();
    send_text("29/2/1900");
    send_text("29/2/2023");
    send_text("31/4/2021");
    send_text("0/5/2020");
    send_text("5/13/2020");
    send_text("5/5/0");
    send_text("1/1/65536");
    send_text("123/1/2000");
  endtask

  task automatic test_format_errors();
    send_text("1/1/2000x");
    send_text("1//2000");
    send_text("/1/2000");
    send_text("1/1/");
    send_text("1/1/2000 5");
  endtask

  task automatic test_blank_and_nul_lines();
    logic [7:0] txt[$];
    send_text("");
    txt = {ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr};
    send_line(txt);
    // Text after a NUL is not parsed.
    txt = {};
    add_text(txt, "1/2/2003");
    txt.push_back(ChNul);
    add_text(txt, "9/x");
    send_line(txt);
    // A NUL straight after the blanks leaves no date, so the line is reported invalid.
    txt = {ChSpace, ChNul};
    send_line(txt);
  endtask

  task automatic test_line_length();
    logic [7:0] txt[$];
    add_text(txt, "1/1/2000");
    repeat (MaxChars - txt.size()) txt.push_back(ChSpace);
    send_line(txt);
    txt.push_back(ChSpace);
    send_line(txt);
  endtask

  task automatic test_random_lines(int unsigned sender_idle, int unsigned receiver_stall,
                                   int unsigned beats);
    logic [7:0]  txt[$];
    int unsigned sent;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    sent      = 0;
    while (sent < beats) begin
      build_random_line(txt);
      send_line(txt);
      sent += txt.size() + 1;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    mismatch_cnt = 0;
    clear_line_parser();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_valid_dates();
    test_calendar_rejects();
    test_format_errors();
    test_blank_and_nul_lines();
    test_line_length();

    test_random_lines(0, 0, 250);
    test_random_lines(88, 0, 250);
    test_random_lines(0, 88, 250);
    test_random_lines(15, 15, 250);

    // Drop valid, let every queued date come out, then watch for strays.
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DrainTail) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
